>>> rtl/fct_pkg.sv
// types and constants shared by the frustum cull test block
// no dependencies

package fct_pkg;

   localparam int PLANE_COUNT    = 6;
   localparam int NUM_PLANE_REGS = 6;
   localparam int CELL_COUNT     = (PLANE_COUNT < NUM_PLANE_REGS) ? PLANE_COUNT : NUM_PLANE_REGS;
   localparam int CELL_LATENCY   = 2;
   localparam int LATENCY        = CELL_COUNT * CELL_LATENCY;

   localparam int CSR_INDEX_W = 3;
   localparam int PLANE_W     = 64;
   localparam int COORD_W     = 16;
   localparam int NORM_W      = 12;
   localparam int DIST_W      = 28;
   localparam int PROD_W      = 28;
   localparam int SUM_W       = 32;
   localparam int RADIUS_W    = 15;
   localparam int RAD_FRAC    = 10;
   localparam int RAD_W       = RADIUS_W + RAD_FRAC;

   // plane packing
   localparam int NX_LSB = 52;
   localparam int NY_LSB = 40;
   localparam int NZ_LSB = 28;
   localparam int D_LSB  = 0;

   localparam logic MODE_BOX    = 1'b0;
   localparam logic MODE_SPHERE = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [PROD_W-1:0]  prod_type;

   // one volume in flight: per-axis low and high coordinate, sphere slack and running verdict
   typedef struct packed {
      coord_type        lo_x;
      coord_type        lo_y;
      coord_type        lo_z;
      coord_type        hi_x;
      coord_type        hi_y;
      coord_type        hi_z;
      logic [RAD_W-1:0] rad;
      logic             visible;
   } item_type;

endpackage

>>> rtl/fct_cell.sv
// one plane cell of the frustum cull chain: holds a plane, tests the passing volume
// depends on fct_pkg

module fct_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [fct_pkg::PLANE_W-1:0]  wr_data,
   input  logic                         in_valid,
   input  fct_pkg::item_type            in_item,
   output logic                         out_valid,
   output fct_pkg::item_type            out_item
);

   logic [fct_pkg::PLANE_W-1:0] plane_ff;

   logic signed [fct_pkg::PROD_W-1:0] nx, ny, nz;
   logic signed [fct_pkg::PROD_W-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;

   fct_pkg::prod_type plo_x_in, plo_y_in, plo_z_in, phi_x_in, phi_y_in, phi_z_in;
   fct_pkg::prod_type plo_x_ff, plo_y_ff, plo_z_ff, phi_x_ff, phi_y_ff, phi_z_ff;
   fct_pkg::item_type item1_ff;
   logic              valid1_ff;

   fct_pkg::prod_type                mx_x, mx_y, mx_z;
   logic signed [fct_pkg::SUM_W-1:0] d_val, rad_s, sum;
   fct_pkg::item_type                item2_in, item2_ff;
   logic                             valid2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
      end else if (wr_en) begin
         plane_ff <= wr_data;
      end
   end

   // stage 1: six products
   always_comb begin
      nx = fct_pkg::PROD_W'($signed(plane_ff[fct_pkg::NX_LSB +: fct_pkg::NORM_W]));
      ny = fct_pkg::PROD_W'($signed(plane_ff[fct_pkg::NY_LSB +: fct_pkg::NORM_W]));
      nz = fct_pkg::PROD_W'($signed(plane_ff[fct_pkg::NZ_LSB +: fct_pkg::NORM_W]));
      lo_x = fct_pkg::PROD_W'($signed(in_item.lo_x));
      lo_y = fct_pkg::PROD_W'($signed(in_item.lo_y));
      lo_z = fct_pkg::PROD_W'($signed(in_item.lo_z));
      hi_x = fct_pkg::PROD_W'($signed(in_item.hi_x));
      hi_y = fct_pkg::PROD_W'($signed(in_item.hi_y));
      hi_z = fct_pkg::PROD_W'($signed(in_item.hi_z));
      plo_x_in = nx * lo_x;
      plo_y_in = ny * lo_y;
      plo_z_in = nz * lo_z;
      phi_x_in = nx * hi_x;
      phi_y_in = ny * hi_y;
      phi_z_in = nz * hi_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      plo_x_ff <= plo_x_in;
      plo_y_ff <= plo_y_in;
      plo_z_ff <= plo_z_in;
      phi_x_ff <= phi_x_in;
      phi_y_ff <= phi_y_in;
      phi_z_ff <= phi_z_in;
      item1_ff <= in_item;
   end

   // stage 2: greatest corner, plane value and verdict
   always_comb begin
      mx_x  = (plo_x_ff > phi_x_ff) ? plo_x_ff : phi_x_ff;
      mx_y  = (plo_y_ff > phi_y_ff) ? plo_y_ff : phi_y_ff;
      mx_z  = (plo_z_ff > phi_z_ff) ? plo_z_ff : phi_z_ff;
      d_val = fct_pkg::SUM_W'($signed(plane_ff[fct_pkg::D_LSB +: fct_pkg::DIST_W]));
      rad_s = $signed(fct_pkg::SUM_W'(item1_ff.rad));
      sum   = fct_pkg::SUM_W'(mx_x) + fct_pkg::SUM_W'(mx_y) + fct_pkg::SUM_W'(mx_z)
            + d_val + rad_s;
      item2_in         = item1_ff;
      item2_in.visible = item1_ff.visible & (sum > 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      item2_ff <= item2_in;
   end

   assign out_valid = valid2_ff;
   assign out_item  = item2_ff;

   a_valid_delay: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> $past(in_valid, 2))
      else $error("cell output without a transfer two cycles earlier");

   a_verdict_sticky: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_item.visible) |-> $past(in_item.visible, 2))
      else $error("cell revived a rejected volume");

   a_plane_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (plane_ff == $past(wr_data)))
      else $error("plane register missed a write");

endmodule

>>> rtl/frustum_cull_test_unit.sv
// top level of the frustum cull test block: entry select, plane register port, cell chain
// depends on fct_pkg and fct_cell
//
// Usage: configure the six planes through the csr_ write channel (csr_index 0..5 selects
// right, left, bottom, top, far, near; other indexes are dropped). csr_ready is always
// high, so a write is never held off. Each plane packs nx, ny, nz as signed Q1.10 and
// d as a signed 28-bit value with 10 fraction bits.
// A volume transfer happens on a clock edge with start high and busy low; busy is never
// raised, so one volume can enter every cycle. req_mode selects box or sphere test.
// The volume walks a chain of one cell per plane; each cell registers its products, then
// its sum and compare, so the verdict appears on rsp_visible with rsp_strobe for one
// cycle at the end of the chain, and results leave in transfer order at one per cycle.
// The receiver cannot stall; it must take rsp_visible in the strobe cycle.
// Synchronous reset clears all planes to zero and drops every volume in flight.

module frustum_cull_test_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_mode,
   input  logic signed [15:0]                  req_min_x,
   input  logic signed [15:0]                  req_min_y,
   input  logic signed [15:0]                  req_min_z,
   input  logic signed [15:0]                  req_max_x,
   input  logic signed [15:0]                  req_max_y,
   input  logic signed [15:0]                  req_max_z,
   input  logic signed [15:0]                  req_center_x,
   input  logic signed [15:0]                  req_center_y,
   input  logic signed [15:0]                  req_center_z,
   input  logic [14:0]                         req_radius,
   output logic                                rsp_strobe,
   output logic                                rsp_visible,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fct_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fct_pkg::PLANE_W-1:0]         csr_data
);

   fct_pkg::item_type entry_item;
   logic              entry_valid;
   logic              sphere;

   logic              chain_valid [fct_pkg::CELL_COUNT+1];
   fct_pkg::item_type chain_item  [fct_pkg::CELL_COUNT+1];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // sphere uses the center as both corners and adds the radius as slack
   always_comb begin
      sphere = (req_mode == fct_pkg::MODE_SPHERE);
      entry_valid        = start & ~busy;
      entry_item.lo_x    = sphere ? req_center_x : req_min_x;
      entry_item.lo_y    = sphere ? req_center_y : req_min_y;
      entry_item.lo_z    = sphere ? req_center_z : req_min_z;
      entry_item.hi_x    = sphere ? req_center_x : req_max_x;
      entry_item.hi_y    = sphere ? req_center_y : req_max_y;
      entry_item.hi_z    = sphere ? req_center_z : req_max_z;
      entry_item.rad     = sphere ? {req_radius, fct_pkg::RAD_FRAC'(0)} : '0;
      entry_item.visible = 1'b1;
   end

   assign chain_valid[0] = entry_valid;
   assign chain_item[0]  = entry_item;

   for (genvar i = 0; i < fct_pkg::CELL_COUNT; i++) begin : g_cell
      logic wr_en;
      assign wr_en = csr_valid & csr_ready
                   & (csr_index == fct_pkg::CSR_INDEX_W'(i));
      fct_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .wr_en     (wr_en),
         .wr_data   (csr_data),
         .in_valid  (chain_valid[i]),
         .in_item   (chain_item[i]),
         .out_valid (chain_valid[i+1]),
         .out_item  (chain_item[i+1])
      );
   end

   assign rsp_strobe  = chain_valid[fct_pkg::CELL_COUNT];
   assign rsp_visible = chain_item[fct_pkg::CELL_COUNT].visible;

   a_result_follows_transfer: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, fct_pkg::LATENCY))
      else $error("result without a matching volume transfer");

endmodule

>>> dv/frustum_cull_test_unit_checker.sv
// checker for the frustum cull test block: tracks plane writes, predicts each verdict
// and compares it with the result stream
// depends on fct_pkg
`timescale 1ns / 1ps

module frustum_cull_test_unit_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic                            req_mode,
   input  logic signed [15:0]              req_min_x,
   input  logic signed [15:0]              req_min_y,
   input  logic signed [15:0]              req_min_z,
   input  logic signed [15:0]              req_max_x,
   input  logic signed [15:0]              req_max_y,
   input  logic signed [15:0]              req_max_z,
   input  logic signed [15:0]              req_center_x,
   input  logic signed [15:0]              req_center_y,
   input  logic signed [15:0]              req_center_z,
   input  logic [14:0]                     req_radius,
   input  logic                            rsp_strobe,
   input  logic                            rsp_visible,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [fct_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fct_pkg::PLANE_W-1:0]     csr_data,
   output int                              errors,
   output int                              outstanding,
   output int                              checked,
   output int                              shown
);

   logic [fct_pkg::PLANE_W-1:0] plane_copy [fct_pkg::NUM_PLANE_REGS];
   logic                        visible_q [$];
   int                          fail_total = 0;
   int                          result_total = 0;
   int                          visible_total = 0;

   // larger of the two products on one box axis
   function automatic longint axis_peak(input longint n, input longint lo, input longint hi);
      longint a;
      longint b;
      a = n * lo;
      b = n * hi;
      return (a > b) ? a : b;
   endfunction

   // verdict for the volume on the request ports against the tracked planes
   function automatic logic predict_visible();
      longint nx;
      longint ny;
      longint nz;
      longint d;
      longint v;
      longint slack;
      logic   seen;
      seen  = 1'b1;
      slack = longint'(req_radius) << fct_pkg::RAD_FRAC;
      for (int i = 0; i < fct_pkg::CELL_COUNT; i++) begin
         nx = $signed(plane_copy[i][fct_pkg::NX_LSB +: fct_pkg::NORM_W]);
         ny = $signed(plane_copy[i][fct_pkg::NY_LSB +: fct_pkg::NORM_W]);
         nz = $signed(plane_copy[i][fct_pkg::NZ_LSB +: fct_pkg::NORM_W]);
         d  = $signed(plane_copy[i][fct_pkg::D_LSB +: fct_pkg::DIST_W]);
         if (req_mode == fct_pkg::MODE_BOX) begin
            v = axis_peak(nx, req_min_x, req_max_x) + axis_peak(ny, req_min_y, req_max_y)
              + axis_peak(nz, req_min_z, req_max_z) + d;
            if (v <= 0) seen = 1'b0;
         end else begin
            v = nx * longint'(req_center_x) + ny * longint'(req_center_y)
              + nz * longint'(req_center_z) + d;
            if (v <= -slack) seen = 1'b0;
         end
      end
      return seen;
   endfunction

   always @(posedge clock) begin
      logic want;
      if (reset) begin
         for (int i = 0; i < fct_pkg::NUM_PLANE_REGS; i++) plane_copy[i] = '0;
         visible_q.delete();
      end else begin
         if (rsp_strobe) begin
            if (visible_q.size() == 0) begin
               if (fail_total < 10)
                  $display("%0t: result transfer with nothing pending, visible %b",
                           $realtime, rsp_visible);
               fail_total++;
            end else begin
               want = visible_q.pop_front();
               if (rsp_visible !== want) begin
                  if (fail_total < 10)
                     $display("%0t: result %0d visible expected %b, got %b",
                              $realtime, result_total, want, rsp_visible);
                  fail_total++;
               end
               result_total++;
               if (rsp_visible === 1'b1) visible_total++;
            end
         end
         if (start && !busy) visible_q.push_back(predict_visible());
         if (csr_valid && csr_ready && csr_index < fct_pkg::NUM_PLANE_REGS)
            plane_copy[csr_index] = csr_data;
      end
      errors      <= fail_total;
      outstanding <= visible_q.size();
      checked     <= result_total;
      shown       <= visible_total;
   end

endmodule

>>> dv/frustum_cull_test_unit_tb.sv
// testbench top for the frustum cull test block: clock, reset, plane writes and volume stimulus
// depends on fct_pkg, frustum_cull_test_unit and frustum_cull_test_unit_checker
`timescale 1ns / 1ps

module frustum_cull_test_unit_tb;

   localparam int CYCLE_LIMIT = 200000;

   typedef enum logic [fct_pkg::CSR_INDEX_W-1:0] {
      CSR_RIGHT,
      CSR_LEFT,
      CSR_BOTTOM,
      CSR_TOP,
      CSR_FAR,
      CSR_NEAR,
      CSR_SPARE_A,
      CSR_SPARE_B
   } csr_reg_type;

   typedef struct packed {
      logic        mode;
      logic [15:0] min_x;
      logic [15:0] min_y;
      logic [15:0] min_z;
      logic [15:0] max_x;
      logic [15:0] max_y;
      logic [15:0] max_z;
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [15:0] center_z;
      logic [14:0] radius;
   } volume_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic                            req_mode = 1'b0;
   logic signed [15:0]              req_min_x = '0;
   logic signed [15:0]              req_min_y = '0;
   logic signed [15:0]              req_min_z = '0;
   logic signed [15:0]              req_max_x = '0;
   logic signed [15:0]              req_max_y = '0;
   logic signed [15:0]              req_max_z = '0;
   logic signed [15:0]              req_center_x = '0;
   logic signed [15:0]              req_center_y = '0;
   logic signed [15:0]              req_center_z = '0;
   logic [14:0]                     req_radius = '0;
   logic                            rsp_strobe;
   logic                            rsp_visible;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [fct_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [fct_pkg::PLANE_W-1:0]     csr_data = '0;

   int errors;
   int outstanding;
   int checked;
   int shown;

   int                          cycle_count = 0;
   int                          boxes_sent = 0;
   int                          spheres_sent = 0;
   int                          settings_loaded = 0;
   bit                          quiet = 1'b0;
   logic [fct_pkg::PLANE_W-1:0] plane_set [fct_pkg::NUM_PLANE_REGS];

   frustum_cull_test_unit u_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_mode     (req_mode),
      .req_min_x    (req_min_x),
      .req_min_y    (req_min_y),
      .req_min_z    (req_min_z),
      .req_max_x    (req_max_x),
      .req_max_y    (req_max_y),
      .req_max_z    (req_max_z),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_center_z (req_center_z),
      .req_radius   (req_radius),
      .rsp_strobe   (rsp_strobe),
      .rsp_visible  (rsp_visible),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   frustum_cull_test_unit_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_mode     (req_mode),
      .req_min_x    (req_min_x),
      .req_min_y    (req_min_y),
      .req_min_z    (req_min_z),
      .req_max_x    (req_max_x),
      .req_max_y    (req_max_y),
      .req_max_z    (req_max_z),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_center_z (req_center_z),
      .req_radius   (req_radius),
      .rsp_strobe   (rsp_strobe),
      .rsp_visible  (rsp_visible),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .errors       (errors),
      .outstanding  (outstanding),
      .checked      (checked),
      .shown        (shown)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [fct_pkg::PLANE_W-1:0] pack_plane(input int nx, input int ny,
                                                              input int nz, input int d);
      return {nx[fct_pkg::NORM_W-1:0], ny[fct_pkg::NORM_W-1:0], nz[fct_pkg::NORM_W-1:0],
              d[fct_pkg::DIST_W-1:0]};
   endfunction

   function automatic volume_type make_box(input int lx, input int ly, input int lz,
                                           input int hx, input int hy, input int hz);
      volume_type v;
      v       = '0;
      v.mode  = fct_pkg::MODE_BOX;
      v.min_x = 16'(lx);
      v.min_y = 16'(ly);
      v.min_z = 16'(lz);
      v.max_x = 16'(hx);
      v.max_y = 16'(hy);
      v.max_z = 16'(hz);
      return v;
   endfunction

   function automatic volume_type make_sphere(input int cx, input int cy, input int cz,
                                              input int r);
      volume_type v;
      v          = '0;
      v.mode     = fct_pkg::MODE_SPHERE;
      v.center_x = 16'(cx);
      v.center_y = 16'(cy);
      v.center_z = 16'(cz);
      v.radius   = 15'(r);
      return v;
   endfunction

   // mostly small volumes near the planes, some inverted, some anywhere in range
   function automatic volume_type random_volume();
      volume_type v;
      int         shape;
      int         lo [3];
      int         hi [3];
      int         ext;
      v     = {$urandom, $urandom, $urandom, $urandom, $urandom};
      shape = $urandom_range(0, 99);
      for (int a = 0; a < 3; a++) begin
         lo[a] = int'($urandom_range(0, 6000)) - 3000;
         ext   = $urandom_range(0, 800);
         hi[a] = (shape < 10) ? lo[a] - ext : lo[a] + ext;
      end
      if (shape < 80) begin
         if (v.mode == fct_pkg::MODE_BOX) begin
            v.min_x = 16'(lo[0]);
            v.min_y = 16'(lo[1]);
            v.min_z = 16'(lo[2]);
            v.max_x = 16'(hi[0]);
            v.max_y = 16'(hi[1]);
            v.max_z = 16'(hi[2]);
         end else begin
            v.center_x = 16'(lo[0]);
            v.center_y = 16'(lo[1]);
            v.center_z = 16'(lo[2]);
            if (shape < 10)
               v.radius = '0;
            else if (shape < 60)
               v.radius = 15'($urandom_range(0, 1500));
         end
      end
      return v;
   endfunction

   task automatic send_volume(input volume_type v);
      if (!quiet && $urandom_range(0, 99) < 9) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start        <= 1'b1;
      req_mode     <= v.mode;
      req_min_x    <= v.min_x;
      req_min_y    <= v.min_y;
      req_min_z    <= v.min_z;
      req_max_x    <= v.max_x;
      req_max_y    <= v.max_y;
      req_max_z    <= v.max_z;
      req_center_x <= v.center_x;
      req_center_y <= v.center_y;
      req_center_z <= v.center_z;
      req_radius   <= v.radius;
      do @(posedge clock); while (busy);
      if (v.mode == fct_pkg::MODE_BOX) boxes_sent++;
      else spheres_sent++;
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) send_volume(random_volume());
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_csr(input csr_reg_type idx, input logic [fct_pkg::PLANE_W-1:0] value);
      if (!quiet && $urandom_range(0, 99) < 9) begin
         csr_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // unused indexes get junk that the block must drop
   task automatic load_planes();
      wait_drained();
      write_csr(CSR_SPARE_A, {$urandom, $urandom});
      for (int i = 0; i < fct_pkg::NUM_PLANE_REGS; i++)
         write_csr(csr_reg_type'(i), plane_set[i]);
      write_csr(CSR_SPARE_B, {$urandom, $urandom});
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   task automatic load_uniform(input logic [fct_pkg::PLANE_W-1:0] value);
      for (int i = 0; i < fct_pkg::NUM_PLANE_REGS; i++) plane_set[i] = value;
      load_planes();
   endtask

   initial begin
      int h;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // planes still zero from reset
      send_volume(make_box(0, 0, 0, 0, 0, 0));
      send_volume(make_sphere(0, 0, 0, 0));
      send_volume(make_sphere(0, 0, 0, 1));

      // axis-aligned cube frustum, half extent 1500
      h = 1500 << fct_pkg::RAD_FRAC;
      plane_set[CSR_RIGHT]  = pack_plane(-1024, 0, 0, h);
      plane_set[CSR_LEFT]   = pack_plane(1024, 0, 0, h);
      plane_set[CSR_BOTTOM] = pack_plane(0, 1024, 0, h);
      plane_set[CSR_TOP]    = pack_plane(0, -1024, 0, h);
      plane_set[CSR_FAR]    = pack_plane(0, 0, -1024, h);
      plane_set[CSR_NEAR]   = pack_plane(0, 0, 1024, h);
      load_planes();
      send_volume(make_box(-100, -100, -100, 100, 100, 100));
      send_volume(make_box(1600, 0, 0, 1700, 10, 10));
      send_volume(make_box(1500, 0, 0, 1500, 0, 0));
      send_volume(make_box(1499, 0, 0, 1499, 0, 0));
      send_volume(make_box(1700, 0, 0, 1400, 0, 0));
      send_volume(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
      send_volume(make_box(32767, 32767, 32767, -32768, -32768, -32768));
      send_volume(make_sphere(1600, 0, 0, 100));
      send_volume(make_sphere(1600, 0, 0, 101));
      send_volume(make_sphere(-32768, -32768, -32768, 32767));
      send_volume(make_sphere(32767, 32767, 32767, 0));

      quiet = 1'b1;
      send_random(80);
      quiet = 1'b0;
      send_random(45);
      wait_drained();
      send_random(125);

      // oblique planes with moderate offsets
      repeat (3) begin
         for (int i = 0; i < fct_pkg::NUM_PLANE_REGS; i++)
            plane_set[i] = pack_plane(int'($urandom_range(0, 2047)) - 1024,
                                      int'($urandom_range(0, 2047)) - 1024,
                                      int'($urandom_range(0, 2047)) - 1024,
                                      int'($urandom_range(0, 4000000)) - 500000);
         load_planes();
         send_random(60);
      end

      // extreme plane values
      load_uniform(pack_plane(2047, 2047, 2047, (1 << (fct_pkg::DIST_W - 1)) - 1));
      send_volume(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
      send_volume(make_sphere(-32768, -32768, -32768, 0));
      send_random(25);
      load_uniform(pack_plane(-2048, -2048, -2048, -(1 << (fct_pkg::DIST_W - 1))));
      send_volume(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
      send_volume(make_sphere(-32768, -32768, -32768, 32767));
      send_random(25);
      load_uniform('1);
      send_volume(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
      send_volume(make_sphere(-1, -1, -1, 32767));

      // fully random plane words
      repeat (2) begin
         for (int i = 0; i < fct_pkg::NUM_PLANE_REGS; i++) plane_set[i] = {$urandom, $urandom};
         load_planes();
         send_random(25);
      end

      wait_drained();
      repeat (fct_pkg::LATENCY + 4) @(posedge clock);
      $display("sent %0d boxes and %0d spheres across %0d plane settings after reset",
               boxes_sent, spheres_sent, settings_loaded);
      $display("compared %0d verdicts, %0d visible, %0d mismatches", checked, shown, errors);
      if (errors == 0 && outstanding == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> filelist.f
rtl/fct_pkg.sv
rtl/fct_cell.sv
rtl/frustum_cull_test_unit.sv
dv/frustum_cull_test_unit_checker.sv
dv/frustum_cull_test_unit_tb.sv
